// ===== rtl/dqvcl_pkg.sv =====
// Shared widths and types of the dq voltage circle limiter.
package dqvcl_pkg;

	// Width of one voltage component (signed Q1.15 at 16 bits).
	localparam int DW = 16;
	// Width of the magnitude limit register.
	localparam int VW = 15;
	// Width of the limited magnitude; where it is used, it is never above the input magnitude.
	localparam int K_W = DW - 1;
	// Width of the quotient m*m*v*v / s, which stays below m*m.
	localparam int Q_W = 2 * K_W;
	// Width of the squared magnitude d*d + q*q.
	localparam int SQ_W = 2 * DW;
	// Width of a component magnitude times v_max.
	localparam int MV_W = DW + VW;
	// Width of (m*v)^2.
	localparam int T_W = 2 * MV_W;

	// Stage counts of the scaling unit: one quotient bit and one root bit per stage.
	localparam int DIV_ST = Q_W;
	localparam int SQRT_ST = K_W;
	localparam int LAT = DIV_ST + SQRT_ST;

	// Stream payload widths.
	localparam int IN_TDATA_W = 2 * DW;
	localparam int OUT_TDATA_W = 2 * DW;

	// Information that travels beside the scaling units.
	typedef struct packed {
		logic [DW-1:0] d;
		logic [DW-1:0] q;
		logic          d_neg;
		logic          q_neg;
		logic          lim;
	} side_t;

	// One finished result.
	typedef struct packed {
		logic [DW-1:0] d;
		logic [DW-1:0] q;
		logic          lim;
	} res_t;

endpackage

// ===== rtl/dqvcl_scale.sv =====
// Pipelined scaling unit: k = isqrt(floor(t / s)), one bit per register stage.
module dqvcl_scale (
	input  logic                       clk,
	input  logic                       en,
	input  logic [dqvcl_pkg::T_W-1:0]  t,
	input  logic [dqvcl_pkg::SQ_W-1:0] s,
	output logic [dqvcl_pkg::K_W-1:0]  k
);
	import dqvcl_pkg::*;

	// Restoring divider stages.
	logic [SQ_W-1:0] div_rem_s [DIV_ST];
	logic [SQ_W-1:0] div_dsr_s [DIV_ST];
	logic [Q_W-1:0]  div_quo_s [DIV_ST];
	logic [Q_W-1:0]  div_lo_s  [DIV_ST];

	// Digit-by-digit square root stages.
	logic [Q_W-1:0]  sq_rad_s  [SQRT_ST];
	logic [K_W+1:0]  sq_rem_s  [SQRT_ST];
	logic [K_W-1:0]  sq_root_s [SQRT_ST];

	for (genvar i = 0; i < DIV_ST; i++) begin : g_div
		logic [SQ_W-1:0] rem_prev;
		logic [SQ_W-1:0] dsr_prev;
		logic [Q_W-1:0]  quo_prev;
		logic [Q_W-1:0]  lo_prev;
		logic [SQ_W:0]   r2;
		logic            ge;

		if (i == 0) begin : g_first
			// The high part of t is below s whenever the result is used.
			assign rem_prev = SQ_W'(t >> Q_W);
			assign dsr_prev = s;
			assign quo_prev = '0;
			assign lo_prev  = t[Q_W-1:0];
		end else begin : g_next
			assign rem_prev = div_rem_s[i-1];
			assign dsr_prev = div_dsr_s[i-1];
			assign quo_prev = div_quo_s[i-1];
			assign lo_prev  = div_lo_s[i-1];
		end

		assign r2 = {rem_prev, lo_prev[Q_W-1]};
		assign ge = (r2 >= {1'b0, dsr_prev});

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[i] <= ge ? SQ_W'(r2 - {1'b0, dsr_prev}) : r2[SQ_W-1:0];
				div_dsr_s[i] <= dsr_prev;
				div_quo_s[i] <= {quo_prev[Q_W-2:0], ge};
				div_lo_s[i]  <= lo_prev << 1;
			end
		end
	end

	for (genvar j = 0; j < SQRT_ST; j++) begin : g_sqrt
		logic [Q_W-1:0] rad_prev;
		logic [K_W+1:0] rem_prev;
		logic [K_W-1:0] root_prev;
		logic [K_W+3:0] r4;
		logic [K_W+3:0] trial;
		logic           ge;

		if (j == 0) begin : g_first
			assign rad_prev  = div_quo_s[DIV_ST-1];
			assign rem_prev  = '0;
			assign root_prev = '0;
		end else begin : g_next
			assign rad_prev  = sq_rad_s[j-1];
			assign rem_prev  = sq_rem_s[j-1];
			assign root_prev = sq_root_s[j-1];
		end

		// Bring down the next two radicand bits and try the digit one.
		assign r4    = {rem_prev, rad_prev[Q_W-1 -: 2]};
		assign trial = (K_W + 4)'({root_prev, 2'b01});
		assign ge    = (r4 >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_s[j]  <= rad_prev << 2;
				sq_rem_s[j]  <= ge ? (K_W + 2)'(r4 - trial) : r4[K_W+1:0];
				sq_root_s[j] <= {root_prev[K_W-2:0], ge};
			end
		end
	end

	assign k = sq_root_s[SQRT_ST-1];

endmodule

// ===== rtl/dq_voltage_circle_limit.sv =====
// Top level of the dq voltage circle limiter.
// This block limits the magnitude of a field-oriented-control voltage vector
// (d, q), both signed Q1.15, to the register v_max. When d*d + q*q exceeds
// v_max*v_max, each component is replaced by component * v_max / sqrt(d*d + q*q),
// truncated toward zero and computed exactly in integers; otherwise the vector
// passes unchanged. The result carries a flag in tuser that is set when the
// vector was scaled. A vector whose magnitude equals the limit is not scaled,
// and with v_max at zero every nonzero vector becomes (0, 0) with the flag set.
// The block takes one request per clock cycle while the pipeline is not held. Once
// a request is accepted, three stages form the squares and products, thirty
// restoring-divider stages and fifteen square-root stages (one bit each) find
// the scaled magnitude, and one output register holds the result. A second
// output register catches a result pushed while the sink refuses the output;
// the whole pipeline holds only while that register is full, so s_axis_tready
// comes straight from a flip-flop. Write v_max only while no request is in
// flight.
module dq_voltage_circle_limit (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration: the magnitude limit v_max.
	input  logic                              cfg_wr_en,
	input  logic [dqvcl_pkg::VW-1:0]          cfg_wr_data,
	// Input requests.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// Fields from bit 0 up: d_in[15:0], q_in[31:16].
	input  logic [dqvcl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// Results.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// Fields from bit 0 up: d_out[15:0], q_out[31:16].
	output logic [dqvcl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// Fields from bit 0 up: was_limited[0].
	output logic                              m_axis_tuser
);
	import dqvcl_pkg::*;

	// The limit register.
	logic [VW-1:0] v_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_max_q <= '1;
		end else if (cfg_wr_en) begin
			v_max_q <= cfg_wr_data;
		end
	end

	// The whole pipeline moves together while the spare output register is empty.
	logic adv;
	logic in_acc;
	logic skid_valid_q;

	assign adv           = !skid_valid_q;
	assign s_axis_tready = adv;
	assign in_acc        = s_axis_tvalid && adv;

	// Stage 1: register the components and take their magnitudes.
	logic          valid_s1;
	logic [DW-1:0] d_s1, q_s1;
	logic [DW-1:0] dm_s1, qm_s1;
	logic [VW-1:0] v_s1;
	logic [DW-1:0] d_in, q_in;

	assign d_in = s_axis_tdata[DW-1:0];
	assign q_in = s_axis_tdata[2*DW-1:DW];

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1  <= d_in;
			q_s1  <= q_in;
			// The most negative value gives the unsigned magnitude 2^(DW-1).
			dm_s1 <= d_in[DW-1] ? (~d_in + 1'b1) : d_in;
			qm_s1 <= q_in[DW-1] ? (~q_in + 1'b1) : q_in;
			v_s1  <= v_max_q;
		end
	end

	// Stage 2: squares of the magnitudes and of the limit, magnitudes times the limit.
	logic            valid_s2;
	logic [DW-1:0]   d_s2, q_s2;
	logic [SQ_W-1:0] dd_s2, qq_s2;
	logic [MV_W-1:0] dv_s2, qv_s2;
	logic [2*VW-1:0] vv_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2  <= d_s1;
			q_s2  <= q_s1;
			dd_s2 <= dm_s1 * dm_s1;
			qq_s2 <= qm_s1 * qm_s1;
			dv_s2 <= MV_W'(dm_s1) * MV_W'(v_s1);
			qv_s2 <= MV_W'(qm_s1) * MV_W'(v_s1);
			vv_s2 <= (2 * VW)'(v_s1) * (2 * VW)'(v_s1);
		end
	end

	// Stage 3: squared magnitude, the limit decision and the dividends (m*v)^2.
	logic            valid_s3;
	side_t           side_s3;
	logic [SQ_W-1:0] s_s3;
	logic [T_W-1:0]  td_s3, tq_s3;
	logic [SQ_W-1:0] sum_s2;

	assign sum_s2 = dd_s2 + qq_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.d     <= d_s2;
			side_s3.q     <= q_s2;
			side_s3.d_neg <= d_s2[DW-1];
			side_s3.q_neg <= q_s2[DW-1];
			side_s3.lim   <= (sum_s2 > SQ_W'(vv_s2));
			s_s3          <= sum_s2;
			td_s3         <= T_W'(dv_s2) * T_W'(dv_s2);
			tq_s3         <= T_W'(qv_s2) * T_W'(qv_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Scaled magnitudes: floor(m*v / sqrt(s)) = isqrt(floor(m*m*v*v / s)).
	logic [K_W-1:0] kd, kq;

	dqvcl_scale u_scale_d (
		.clk (clk),
		.en  (adv),
		.t   (td_s3),
		.s   (s_s3),
		.k   (kd)
	);

	dqvcl_scale u_scale_q (
		.clk (clk),
		.en  (adv),
		.t   (tq_s3),
		.s   (s_s3),
		.k   (kq)
	);

	// The original vector, signs and decision travel beside the scaling units.
	side_t side_s [LAT];
	logic  vld_s  [LAT];

	for (genvar i = 0; i < LAT; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[i] <= (i == 0) ? side_s3 : side_s[(i == 0) ? 0 : i - 1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= (i == 0) ? valid_s3 : vld_s[(i == 0) ? 0 : i - 1];
			end
		end
	end

	// Put the signs back on the scaled magnitudes, or pass the vector through.
	side_t         side_last;
	res_t          res_new;
	logic [DW-1:0] kd_ext, kq_ext;
	logic          push;

	assign side_last = side_s[LAT-1];
	assign kd_ext    = DW'(kd);
	assign kq_ext    = DW'(kq);
	assign push      = vld_s[LAT-1] && adv;

	always_comb begin
		res_new.lim = side_last.lim;
		if (side_last.lim) begin
			res_new.d = side_last.d_neg ? (~kd_ext + 1'b1) : kd_ext;
			res_new.q = side_last.q_neg ? (~kq_ext + 1'b1) : kq_ext;
		end else begin
			res_new.d = side_last.d;
			res_new.q = side_last.q;
		end
	end

	// Output register and the spare register behind it.
	logic out_valid_q;
	res_t out_q, skid_q;
	logic pop;

	assign pop = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : res_new;
		end else if (push) begin
			skid_q <= res_new;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.q, out_q.d};
	assign m_axis_tuser  = out_q.lim;

`ifndef SYNTHESIS
	// The spare register only holds a result while the output register does.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("spare result held without an output result");

	// The spare register fills only when the sink refused the output.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
		else $error("spare register filled while the output was moving");

	// Only a nonzero vector can exceed the limit.
	a_lim_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(push && side_last.lim) |-> (side_last.d != '0 || side_last.q != '0))
		else $error("zero vector flagged as limited");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the dq voltage circle limiter.
`timescale 1ns / 100ps

module testbench;
	import dqvcl_pkg::*;

	// A run ends in failure when this many cycles pass with no request and no result moving.
	localparam int STALL_LIMIT = 2000;
	// Length of the long sink hold-off used to fill the pipeline.
	localparam int HOLD_CYCLES = 300;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [VW-1:0]          cfg_wr_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// Fields from bit 0 up: d_in[15:0], q_in[31:16].
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// Fields from bit 0 up: d_out[15:0], q_out[31:16].
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// Fields from bit 0 up: was_limited[0].
	logic                   m_axis_tuser;

	// Our copy of the limit register, updated whenever the testbench writes it.
	logic [VW-1:0] vmax_now = {VW{1'b1}};
	// Limited vectors predicted for accepted requests, oldest first.
	res_t          limited_due[$];
	res_t          due;
	int            mismatches = 0;
	int            quiet_cycles = 0;
	// Idle percentages of the request side and the result side.
	int            src_idle_pct = 0;
	int            sink_stall_pct = 0;
	// Cycles the sink still has to hold off; set by a test, counted down by the sink.
	int            hold_left = 0;

	dq_voltage_circle_limit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Largest k with k*k*s <= m*m*v*v, found one bit at a time from the top.
	// All products stay below 2^63, so plain 64-bit arithmetic is exact.
	function automatic logic [DW-1:0] scaled_magnitude(longint unsigned m, longint unsigned s,
			longint unsigned v);
		longint unsigned bound;
		longint unsigned k;
		longint unsigned trial;
		int              b;
		bound = m * m * v * v;
		k = 0;
		for (b = DW - 1; b >= 0; b--) begin
			trial = k | (64'd1 << b);
			if (trial * trial * s <= bound)
				k = trial;
		end
		return k[DW-1:0];
	endfunction

	// Predicts the limiter output for one vector under the given limit.
	function automatic res_t limit_vector(logic signed [DW-1:0] d, logic signed [DW-1:0] q,
			logic [VW-1:0] vmax);
		res_t            r;
		longint          ds;
		longint          qs;
		longint unsigned dm;
		longint unsigned qm;
		longint unsigned s;
		longint unsigned v;
		logic [DW-1:0]   dk;
		logic [DW-1:0]   qk;
		ds = longint'(d);
		qs = longint'(q);
		// The most negative input has magnitude 2^(DW-1), which still fits here.
		dm = (ds < 0) ? longint'(-ds) : ds;
		qm = (qs < 0) ? longint'(-qs) : qs;
		s = dm * dm + qm * qm;
		v = longint'(vmax);
		if (s > v * v) begin
			dk = scaled_magnitude(dm, s, v);
			qk = scaled_magnitude(qm, s, v);
			r.d = (ds < 0) ? -dk : dk;
			r.q = (qs < 0) ? -qk : qk;
			r.lim = 1'b1;
		end else begin
			// A vector on or inside the circle passes unchanged with the flag clear.
			r.d = d;
			r.q = q;
			r.lim = 1'b0;
		end
		return r;
	endfunction

	// One random vector, packed as {q, d}. The largest share is spread over the full range, many sit
	// within a count or two of the circle, and the rest are small or at the extremes.
	function automatic logic [IN_TDATA_W-1:0] random_vector();
		int          v;
		int          dv;
		int          qv;
		logic [DW-1:0] dr;
		logic [DW-1:0] qr;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				dr = DW'($urandom);
				qr = DW'($urandom);
			end
			4, 5, 6: begin
				v = int'(vmax_now);
				dv = $urandom_range(v);
				qv = int'($sqrt(real'(v * v - dv * dv))) + int'($urandom_range(4)) - 2;
				if ($urandom_range(1))
					dv = -dv;
				if ($urandom_range(1))
					qv = -qv;
				if (qv > 32767)
					qv = 32767;
				if (qv < -32768)
					qv = -32768;
				// Swap axes half the time so either component can be the large one.
				if ($urandom_range(1)) begin
					dr = dv[DW-1:0];
					qr = qv[DW-1:0];
				end else begin
					dr = qv[DW-1:0];
					qr = dv[DW-1:0];
				end
			end
			7: begin
				dr = DW'($urandom_range(31) - 16);
				qr = DW'($urandom_range(31) - 16);
			end
			8: begin
				dr = ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
				qr = DW'($urandom);
			end
			default: begin
				dr = ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
				qr = ($urandom_range(1)) ? 16'h8000 : 16'hFFFF;
			end
		endcase
		return {qr, dr};
	endfunction

	// Sink side: random stalls, plus a long hold-off whenever a test asks for one.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Prediction on every accepted request, comparison on every accepted result.
	// Outputs are read at the clock edge, before any nonblocking update of that edge lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				limited_due.push_back(limit_vector(s_axis_tdata[DW-1:0],
					s_axis_tdata[2*DW-1:DW], vmax_now));
			if (m_axis_tvalid && m_axis_tready) begin
				if (limited_due.size() == 0) begin
					$error("result with no request pending: d_out %0d, q_out %0d",
						$signed(m_axis_tdata[DW-1:0]), $signed(m_axis_tdata[2*DW-1:DW]));
					mismatches++;
				end else begin
					due = limited_due.pop_front();
					if (m_axis_tdata[DW-1:0] !== due.d) begin
						$error("d_out mismatch: expected %0d, actual %0d", $signed(due.d),
							$signed(m_axis_tdata[DW-1:0]));
						mismatches++;
					end
					if (m_axis_tdata[2*DW-1:DW] !== due.q) begin
						$error("q_out mismatch: expected %0d, actual %0d", $signed(due.q),
							$signed(m_axis_tdata[2*DW-1:DW]));
						mismatches++;
					end
					if (m_axis_tuser !== due.lim) begin
						$error("was_limited mismatch: expected %0b, actual %0b", due.lim,
							m_axis_tuser);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog: any cycle in which a request or a result moves resets the count.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Offers one request and returns at the edge where it is taken. The valid is left high,
	// so back-to-back requests need no gap; callers that stop sending go through
	// wait_drain, which lowers it in the same step as the last acceptance.
	task automatic send_vector(input logic signed [DW-1:0] d, input logic signed [DW-1:0] q);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {q, d};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Stops offering requests and waits until every predicted result has come back.
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (limited_due.size() != 0)
			@(posedge clk);
	endtask

	// Writes the limit register; only called with nothing in flight.
	task automatic set_vmax(input logic [VW-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		vmax_now = value;
	endtask

	// The limit left at its reset value of full scale: corners of the square and the most
	// negative inputs. A positive full-scale vector along one axis sits exactly on the circle.
	task automatic test_full_scale_limit();
		send_vector(0, 0);
		send_vector(32767, 0);
		send_vector(-32768, 0);
		send_vector(0, -32768);
		send_vector(32767, 32767);
		send_vector(-32768, -32768);
		send_vector(-32768, 32767);
		send_vector(1, -1);
		wait_drain();
	endtask

	// A small limit where 3-4-5 vectors land exactly on the circle and pass unchanged.
	task automatic test_exact_boundary();
		set_vmax(5);
		send_vector(3, 4);
		send_vector(-3, -4);
		send_vector(4, 4);
		send_vector(5, -1);
		send_vector(0, 6);
		wait_drain();
	endtask

	// With a zero limit every nonzero vector collapses to the origin with the flag set.
	task automatic test_zero_limit();
		set_vmax(0);
		send_vector(0, 0);
		send_vector(1, 0);
		send_vector(0, -1);
		send_vector(-32768, -32768);
		send_vector(32767, -32768);
		wait_drain();
	endtask

	// The smallest nonzero limit.
	task automatic test_unit_limit();
		set_vmax(1);
		send_vector(1, 0);
		send_vector(1, 1);
		send_vector(-1, 0);
		wait_drain();
	endtask

	// Random vectors under one limit setting and one idling pattern.
	task automatic test_random_traffic(input int src_pct, input int sink_pct,
			input logic [VW-1:0] limit, input int count);
		logic [IN_TDATA_W-1:0] vec;
		int                    n;
		set_vmax(limit);
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (n = 0; n < count; n++) begin
			vec = random_vector();
			send_vector(vec[DW-1:0], vec[2*DW-1:DW]);
		end
		wait_drain();
	endtask

	// The sink holds off long enough for the pipeline to fill and push back on the sender,
	// which keeps offering requests all the while; afterwards the sender pauses until the
	// last result is out.
	task automatic test_backpressure();
		logic [IN_TDATA_W-1:0] vec;
		int                    n;
		set_vmax(VW'($urandom_range(1, 32766)));
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_left = HOLD_CYCLES;
		for (n = 0; n < 150; n++) begin
			vec = random_vector();
			send_vector(vec[DW-1:0], vec[2*DW-1:DW]);
		end
		wait_drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_scale_limit();
		test_exact_boundary();
		test_zero_limit();
		test_unit_limit();

		// Idling phases: none, sender idle, receiver stalling, both.
		test_random_traffic(0, 0, 15'h7FFF, 420);
		test_random_traffic(61, 0, VW'($urandom_range(1, 32766)), 420);
		test_random_traffic(0, 61, VW'($urandom_range(1, 2000)), 420);
		test_random_traffic(24, 24, VW'($urandom_range(16384, 32767)), 420);
		test_backpressure();

		// Let any stray result show up before the verdict.
		repeat (LAT + 10) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
